FILE: rtl/tfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the triggered force capture block.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 120;

  // register reset values and the qualify counter limit
  localparam logic signed [31:0] RST_TRIGGER_LEVEL   = 32'sd8000;
  localparam logic        [3:0]  RST_TRIGGER_RUN     = 4'd3;
  localparam logic        [30:0] RST_STOP_LEVEL      = 31'd3200;
  localparam logic        [31:0] RST_STOP_HOLD_US    = 32'd500000;
  localparam logic        [31:0] RST_MAX_TEST_US     = 32'd10000000;
  localparam logic        [15:0] RST_RECORD_CAPACITY = 16'd16384;
  localparam logic        [3:0]  QUALIFY_MAX         = 4'd15;

  typedef enum logic [2:0] {
    CFG_TRIGGER_LEVEL   = 3'd0,
    CFG_TRIGGER_RUN     = 3'd1,
    CFG_STOP_LEVEL      = 3'd2,
    CFG_STOP_HOLD_US    = 3'd3,
    CFG_MAX_TEST_US     = 3'd4,
    CFG_RECORD_CAPACITY = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ARM    = 2'd1,
    OP_STOP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_REC   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REASON_NONE   = 3'd0,
    REASON_FULL   = 3'd1,
    REASON_MAXT   = 3'd2,
    REASON_BURN   = 3'd3,
    REASON_MANUAL = 3'd4
  } reason_e;

  typedef struct packed {
    logic [31:0]        ts;
    logic signed [31:0] frc;
  } ring_entry_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic rd;
  } ring_cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        elapsed;
    logic signed [31:0] rec_force;
    logic signed [31:0] peak;
    mode_e              mode;
    reason_e            reason;
    logic [15:0]        count;
    logic               acc;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/triggered_force_capture.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triggered_force_capture
// Load-cell capture with a pre-trigger ring, threshold trigger and end-of-test
// detection. Emits status, sample and end-of-test records.
// ----------------------------------------------------------------------------
// An accepted word's results wait in pending registers and reach the output
//   register from the emit states; output stalls hold them there.
// No new word is taken until the last one's records are handed off; a trigger
//   word instead replays the ring entry by entry (ring read, then hand-off).
// Reset: control state and registers return to their defaults at once; the ring
//   contents stay undefined and are only read after being written.
// ----------------------------------------------------------------------------
module triggered_force_capture #(
  parameter int unsigned PRETRIGGER_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // force_req, timestamp_us
  input  wire logic [tfc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // operation
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // elapsed_us, record_force, peak_force, mode, end_reason, record_count,
  // accepted, zero pad
  output logic [tfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import tfc_pkg::*;

  localparam int unsigned AW = $clog2(PRETRIGGER_DEPTH);
  localparam int unsigned CW = $clog2(PRETRIGGER_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IN, ST_EMIT0, ST_EMIT1, ST_RD, ST_RP
  } state_e;

  // configuration
  logic signed [31:0] cfg_level_q;
  logic [3:0]         cfg_run_q;
  logic [30:0]        cfg_stop_q;
  logic [31:0]        cfg_hold_q;
  logic [31:0]        cfg_maxt_q;
  logic [15:0]        cfg_cap_q;

  // control state
  state_e             state_q;
  mode_e              mode_q, mode_d;
  logic [3:0]         qual_q, qual_d;
  logic               bact_q, bact_d;
  logic [31:0]        bstart_q, bstart_d;
  logic [31:0]        ttime_q, ttime_d;
  logic [31:0]        origin_q;
  logic signed [31:0] peak_q, peak_d;
  logic [15:0]        stored_q, stored_d;
  logic [AW-1:0]      rp_ptr_q;
  logic [CW-1:0]      rp_left_q;
  logic               first_q;
  res_t               pend_a_q, pend_b_q;
  logic               two_q;

  // datapath
  op_e                op;
  logic signed [31:0] force_in;
  logic [31:0]        ts_in;
  logic               s_acc;
  logic [31:0]        elapsed, since_trig, since_below, mag;
  logic [3:0]         qual_inc;
  logic [CW-1:0]      n_rep;
  logic               replay_go, two_d;
  kind_e              a_kind;
  logic [31:0]        a_elapsed;
  logic signed [31:0] a_force;
  reason_e            a_reason, b_reason;
  logic               a_acc;
  res_t               res_a, res_b, res_rp, out_res;
  logic               out_push, out_rdy;

  ring_cmd_t          ring_cmd;
  ring_entry_t        ring_rdata;
  logic [AW-1:0]      push_oldest;
  logic [CW-1:0]      push_fill;

  assign op            = op_e'(s_axis_tuser);
  assign force_in      = $signed(s_axis_tdata[31:0]);
  assign ts_in         = s_axis_tdata[63:32];
  assign s_axis_tready = (state_q == ST_IN);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_level_q <= RST_TRIGGER_LEVEL;
      cfg_run_q   <= RST_TRIGGER_RUN;
      cfg_stop_q  <= RST_STOP_LEVEL;
      cfg_hold_q  <= RST_STOP_HOLD_US;
      cfg_maxt_q  <= RST_MAX_TEST_US;
      cfg_cap_q   <= RST_RECORD_CAPACITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIGGER_LEVEL:   cfg_level_q <= $signed(cfg_wdata_i);
        CFG_TRIGGER_RUN:     cfg_run_q   <= cfg_wdata_i[3:0];
        CFG_STOP_LEVEL:      cfg_stop_q  <= cfg_wdata_i[30:0];
        CFG_STOP_HOLD_US:    cfg_hold_q  <= cfg_wdata_i;
        CFG_MAX_TEST_US:     cfg_maxt_q  <= cfg_wdata_i;
        CFG_RECORD_CAPACITY: cfg_cap_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  tfc_ring #(
    .Depth(PRETRIGGER_DEPTH)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ring_cmd),
    .wdata_i      ('{ts: ts_in, frc: force_in}),
    .rd_addr_i    (rp_ptr_q),
    .rdata_o      (ring_rdata),
    .push_oldest_o(push_oldest),
    .push_fill_o  (push_fill)
  );

  // replay length: ring fill after the trigger sample, capped by the store
  assign n_rep = (cfg_cap_q < 16'(push_fill)) ? cfg_cap_q[CW-1:0] : push_fill;

  always_comb begin
    elapsed     = ts_in - origin_q;
    since_trig  = ts_in - ttime_q;
    since_below = ts_in - (bact_q ? bstart_q : ts_in);
    mag         = force_in[31] ? (32'd0 - force_in) : force_in;
    qual_inc    = (qual_q == QUALIFY_MAX) ? qual_q : qual_q + 1'b1;

    mode_d    = mode_q;
    qual_d    = qual_q;
    bact_d    = bact_q;
    bstart_d  = bstart_q;
    ttime_d   = ttime_q;
    peak_d    = peak_q;
    stored_d  = stored_q;
    two_d     = 1'b0;
    replay_go = 1'b0;
    a_kind    = KIND_STATUS;
    a_elapsed = '0;
    a_force   = '0;
    a_reason  = REASON_NONE;
    b_reason  = REASON_NONE;
    a_acc     = 1'b0;
    ring_cmd  = '{push: 1'b0, clear: 1'b0, rd: (state_q == ST_RD)};

    unique case (op)
      OP_SAMPLE: begin
        a_force = force_in;
        if (mode_q == MODE_REC) begin
          a_elapsed = elapsed;
          if (stored_q >= cfg_cap_q) begin
            mode_d   = MODE_IDLE;
            a_kind   = KIND_END;
            a_reason = REASON_FULL;
          end else begin
            a_kind   = KIND_RECORD;
            stored_d = stored_q + 1'b1;
            if (force_in > peak_q) begin
              peak_d = force_in;
            end
            if (since_trig >= cfg_maxt_q) begin
              b_reason = REASON_MAXT;
            end else if (mag < {1'b0, cfg_stop_q}) begin
              if (!bact_q) begin
                bact_d   = 1'b1;
                bstart_d = ts_in;
              end
              if (since_below >= cfg_hold_q) begin
                b_reason = REASON_BURN;
              end
            end else begin
              bact_d = 1'b0;
            end
            if (b_reason != REASON_NONE) begin
              mode_d = MODE_IDLE;
              two_d  = 1'b1;
            end
          end
        end else if (mode_q == MODE_ARMED) begin
          ring_cmd.push = 1'b1;
          if (force_in >= cfg_level_q) begin
            qual_d = qual_inc;
            if (qual_inc >= cfg_run_q) begin
              ttime_d   = ts_in;
              peak_d    = force_in;
              stored_d  = '0;
              qual_d    = '0;
              bact_d    = 1'b0;
              bstart_d  = '0;
              mode_d    = MODE_REC;
              replay_go = (n_rep != '0);
            end
          end else begin
            qual_d = '0;
          end
        end
      end
      OP_ARM: begin
        if (mode_q == MODE_IDLE) begin
          peak_d         = '0;
          qual_d         = '0;
          bact_d         = 1'b0;
          bstart_d       = '0;
          stored_d       = '0;
          ring_cmd.clear = 1'b1;
          mode_d         = MODE_ARMED;
          a_acc          = 1'b1;
        end
      end
      OP_STOP: begin
        if (mode_q == MODE_REC) begin
          mode_d   = MODE_IDLE;
          a_kind   = KIND_END;
          a_reason = REASON_MANUAL;
        end else if (mode_q == MODE_ARMED) begin
          stored_d       = '0;
          qual_d         = '0;
          ring_cmd.clear = 1'b1;
          mode_d         = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // touch the ring only for an accepted word
    ring_cmd.push  = ring_cmd.push && s_acc;
    ring_cmd.clear = ring_cmd.clear && s_acc;

    res_a = '{kind: a_kind, elapsed: a_elapsed, rec_force: a_force, peak: peak_d,
              mode: mode_d, reason: a_reason, count: stored_d, acc: a_acc,
              last: !two_d};
    res_b = '{kind: KIND_END, elapsed: a_elapsed, rec_force: a_force, peak: peak_d,
              mode: mode_d, reason: b_reason, count: stored_d, acc: 1'b0,
              last: 1'b1};
  end

  // replayed ring record; the first one sets the time origin
  assign res_rp = '{kind: KIND_RECORD,
                    elapsed: first_q ? 32'd0 : ring_rdata.ts - origin_q,
                    rec_force: ring_rdata.frc, peak: peak_q, mode: MODE_REC,
                    reason: REASON_NONE, count: stored_q + 1'b1, acc: 1'b0,
                    last: (rp_left_q == CW'(1))};

  always_comb begin
    unique case (state_q)
      ST_EMIT1: out_res = pend_b_q;
      ST_RP:    out_res = res_rp;
      default:  out_res = pend_a_q;
    endcase
    out_push = out_rdy &&
               (state_q == ST_EMIT0 || state_q == ST_EMIT1 || state_q == ST_RP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IN;
      mode_q    <= MODE_IDLE;
      qual_q    <= '0;
      bact_q    <= 1'b0;
      bstart_q  <= '0;
      ttime_q   <= '0;
      origin_q  <= '0;
      peak_q    <= '0;
      stored_q  <= '0;
      rp_ptr_q  <= '0;
      rp_left_q <= '0;
      first_q   <= 1'b0;
      pend_a_q  <= '0;
      pend_b_q  <= '0;
      two_q     <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IN: begin
          if (s_acc) begin
            mode_q   <= mode_d;
            qual_q   <= qual_d;
            bact_q   <= bact_d;
            bstart_q <= bstart_d;
            ttime_q  <= ttime_d;
            peak_q   <= peak_d;
            stored_q <= stored_d;
            pend_a_q <= res_a;
            pend_b_q <= res_b;
            two_q    <= two_d;
            if (replay_go) begin
              rp_ptr_q  <= push_oldest;
              rp_left_q <= n_rep;
              first_q   <= 1'b1;
              state_q   <= ST_RD;
            end else begin
              state_q <= ST_EMIT0;
            end
          end
        end
        ST_EMIT0: begin
          if (out_rdy) begin
            state_q <= two_q ? ST_EMIT1 : ST_IN;
          end
        end
        ST_EMIT1: begin
          if (out_rdy) begin
            state_q <= ST_IN;
          end
        end
        ST_RD: begin
          state_q <= ST_RP;
        end
        ST_RP: begin
          if (out_rdy) begin
            stored_q <= stored_q + 1'b1;
            if (first_q) begin
              origin_q <= ring_rdata.ts;
            end
            first_q   <= 1'b0;
            rp_ptr_q  <= (rp_ptr_q == AW'(PRETRIGGER_DEPTH - 1)) ? '0 : rp_ptr_q + 1'b1;
            rp_left_q <= rp_left_q - 1'b1;
            state_q   <= (rp_left_q == CW'(1)) ? ST_IN : ST_RD;
          end
        end
        default: state_q <= ST_IN;
      endcase
    end
  end

  tfc_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (out_push),
    .res_i        (out_res),
    .rdy_o        (out_rdy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // an accepted word always moves the sequencer out of the input state, so back-to-back accepts cannot happen
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

  a_ring_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_cmd.rd && (ring_cmd.push || ring_cmd.clear)))
    else $error("ring read overlaps a ring update");

  a_replay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_RP) |-> rp_left_q != '0)
    else $error("replay running with no entries left");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> (m_axis_tdata[97:96] == MODE_IDLE))
    else $error("end-of-test record not in idle mode");

endmodule
`default_nettype wire

FILE: rtl/tfc_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_ring
// Pre-trigger ring: sample memory with one write port and a registered read
// port, plus the write index and fill count.
// ----------------------------------------------------------------------------
module tfc_ring #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = $clog2(Depth),
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tfc_pkg::ring_cmd_t   cmd_i,
  input  wire tfc_pkg::ring_entry_t wdata_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output tfc_pkg::ring_entry_t      rdata_o,
  output logic [AW-1:0]            push_oldest_o,
  output logic [CW-1:0]            push_fill_o
);
  import tfc_pkg::*;

  ring_entry_t   mem_q [Depth];
  ring_entry_t   rdata_q;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] fill_q, fill_d;

  always_comb begin
    wr_idx_d = (wr_idx_q == AW'(Depth - 1)) ? '0 : wr_idx_q + 1'b1;
    fill_d   = (fill_q == CW'(Depth)) ? fill_q : fill_q + 1'b1;
  end

  // oldest entry and fill as they stand once the current word is pushed
  assign push_oldest_o = (fill_d == CW'(Depth)) ? wr_idx_d : '0;
  assign push_fill_o   = fill_d;
  assign rdata_o       = rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_idx_q] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (cmd_i.clear) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (cmd_i.push) begin
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tfc_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_out_reg
// Output register of the result stream; packs one result into the bus word.
// ----------------------------------------------------------------------------
module tfc_out_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire tfc_pkg::res_t res_i,
  output logic              rdy_o,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // elapsed_us, record_force, peak_force, mode, end_reason, record_count,
  // accepted, zero pad
  output logic [tfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import tfc_pkg::*;

  logic valid_q;
  res_t res_q;

  assign rdy_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b00, res_q.acc, res_q.count, res_q.reason, res_q.mode,
                          res_q.peak, res_q.rec_force, res_q.elapsed};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule
`default_nettype wire
